// ===== design/nsv_pkg.sv =====
// Shared types, constants and helper functions of the NMEA sentence validator.
// Used by every module of the block; depends on nothing else.

package nsv_pkg;

  localparam int MAX_BODY = 255;
  localparam int HEAD_MAX = 8;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [4:0] HEX_BAD     = 5'd16;

  localparam logic [1:0] CFG_HEAD_TEXT       = 2'd0;
  localparam logic [1:0] CFG_HEAD_LENGTH     = 2'd1;
  localparam logic [1:0] CFG_EXPECTED_TOKENS = 2'd2;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_SHORT    = 3'd1;
  localparam logic [2:0] STATUS_HEADER   = 3'd2;
  localparam logic [2:0] STATUS_CHECKSUM = 3'd3;
  localparam logic [2:0] STATUS_TOKENS   = 3'd4;
  localparam logic [2:0] STATUS_OVERLONG = 3'd5;

  typedef struct packed {
    logic [63:0] head_text;
    logic [3:0]  head_len;     // already limited to HEAD_MAX
    logic [8:0]  expected_tokens;
  } nsv_cfg_t;

  typedef struct packed {
    logic            cr_pending;
    logic [7:0]      byte_count;
    logic            overlong;
    logic [2:0][7:0] tail;       // [0] newest, [2] oldest
    logic [7:0]      running_xor;
    logic [7:0]      comma_count;
    logic            head_match;
  } nsv_state_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] body_length;
    logic [8:0] token_count;
    logic [7:0] computed_checksum;
  } nsv_result_t;

  localparam nsv_state_t STATE_CLEAR = '{
    cr_pending:  1'b0,
    byte_count:  8'd0,
    overlong:    1'b0,
    tail:        '0,
    running_xor: 8'd0,
    comma_count: 8'd0,
    head_match:  1'b1
  };

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    begin
      v = HEX_BAD;
      if (c >= 8'h30 && c <= 8'h39) begin
        v = 5'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
        v = 5'(c - 8'h41) + 5'hA;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        v = 5'(c - 8'h61) + 5'hA;
      end
      return v;
    end
  endfunction

  // Adds one byte to the sentence body. The byte leaving the tail window
  // enters the checksum and, past the header and its comma, the comma count.
  function automatic nsv_state_t push_body(input nsv_state_t s, input logic [7:0] b,
                                           input nsv_cfg_t cfg);
    nsv_state_t r;
    logic [7:0] want;
    begin
      r = s;
      want = cfg.head_text[{s.byte_count[2:0], 3'b000} +: 8];
      if (s.byte_count < {4'd0, cfg.head_len} && want != b) begin
        r.head_match = 1'b0;
      end
      if (s.byte_count >= 8'd3) begin
        r.running_xor = s.running_xor ^ s.tail[2];
        if (s.tail[2] == CHAR_COMMA &&
            {1'b0, s.byte_count} >= {5'd0, cfg.head_len} + 9'd4 &&
            s.comma_count != 8'hFF) begin
          r.comma_count = s.comma_count + 8'd1;
        end
      end
      r.tail[2] = s.tail[1];
      r.tail[1] = s.tail[0];
      r.tail[0] = b;
      if (s.byte_count < 8'(MAX_BODY)) begin
        r.byte_count = s.byte_count + 8'd1;
      end else begin
        r.overlong = 1'b1;
      end
      return r;
    end
  endfunction

endpackage

// ===== design/nsv_config.sv =====
// Configuration registers of the NMEA sentence validator.
// Depends on nsv_pkg for the register indexes and the configuration struct.

module nsv_config
  import nsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        cfg_ready,
  output nsv_cfg_t    cfg
);

  logic [63:0] head_text;
  logic [3:0]  head_length;
  logic [8:0]  expected_tokens;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_text       <= 64'd0;
      head_length     <= 4'd5;
      expected_tokens <= 9'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HEAD_TEXT:       head_text       <= cfg_data;
        CFG_HEAD_LENGTH:     head_length     <= cfg_data[3:0];
        CFG_EXPECTED_TOKENS: expected_tokens <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.head_text       = head_text;
    cfg.head_len        = (head_length > 4'(HEAD_MAX)) ? 4'(HEAD_MAX) : head_length;
    cfg.expected_tokens = expected_tokens;
  end

endmodule

// ===== design/nsv_tracker.sv =====
// Sentence framing and running body state: hunts for the dollar sign, feeds
// body bytes through the tail window and flags the CR LF that ends a sentence.
// Depends on nsv_pkg.

module nsv_tracker
  import nsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  nsv_cfg_t   cfg,
  output logic       sentence_end,
  output nsv_state_t state
);

  logic       in_sentence;
  logic       in_sentence_next;
  nsv_state_t state_next;
  nsv_state_t body;

  assign sentence_end = step && in_sentence && state.cr_pending && rx_byte == CHAR_LF;

  // A CR that turns out not to start CR LF goes into the body first, then the
  // current byte is handled; so one byte may push two body bytes.
  always_comb begin
    in_sentence_next = in_sentence;
    state_next       = state;
    body             = state;
    if (step) begin
      if (!in_sentence) begin
        if (rx_byte == CHAR_DOLLAR) begin
          in_sentence_next = 1'b1;
          state_next       = STATE_CLEAR;
        end
      end else if (state.cr_pending && rx_byte == CHAR_LF) begin
        in_sentence_next = 1'b0;
        state_next       = STATE_CLEAR;
      end else begin
        if (state.cr_pending) begin
          body            = push_body(body, CHAR_CR, cfg);
          body.cr_pending = 1'b0;
        end
        if (rx_byte == CHAR_CR) begin
          body.cr_pending = 1'b1;
        end else begin
          body = push_body(body, rx_byte, cfg);
        end
        state_next = body;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence <= 1'b0;
      state       <= STATE_CLEAR;
    end else begin
      in_sentence <= in_sentence_next;
      state       <= state_next;
    end
  end

endmodule

// ===== design/nsv_verdict.sv =====
// Verdict logic: turns the body state at CR LF into status and counters.
// Depends on nsv_pkg.

module nsv_verdict
  import nsv_pkg::*;
(
  input  nsv_state_t  state,
  input  nsv_cfg_t    cfg,
  output nsv_result_t result
);

  logic [4:0] hi;
  logic [4:0] lo;
  logic [8:0] tokens;
  logic       too_short;
  logic       sum_bad;

  assign hi        = hex_val(state.tail[1]);
  assign lo        = hex_val(state.tail[0]);
  assign tokens    = {1'b0, state.comma_count} + 9'd1;
  assign too_short = {1'b0, state.byte_count} < {5'd0, cfg.head_len} + 9'd4;
  assign sum_bad   = hi[4] || lo[4] || {hi[3:0], lo[3:0]} != state.running_xor;

  always_comb begin
    if (too_short) begin
      result.status = STATUS_SHORT;
    end else if (!state.head_match) begin
      result.status = STATUS_HEADER;
    end else if (sum_bad) begin
      result.status = STATUS_CHECKSUM;
    end else if (tokens != cfg.expected_tokens) begin
      result.status = STATUS_TOKENS;
    end else if (state.overlong) begin
      result.status = STATUS_OVERLONG;
    end else begin
      result.status = STATUS_OK;
    end
    result.body_length       = state.byte_count;
    result.token_count       = tokens;
    result.computed_checksum = state.running_xor;
  end

endmodule

// ===== design/nmea_sentence_validator.sv =====
// NMEA 0183 sentence validator: one received byte per transfer, one verdict per CR LF.
// The LF sits in the input register, and its verdict is then taken into the result register,
// from which it can transfer. Throughput: one byte per cycle while no finished verdict waits
// to be taken. Synchronous active-high reset empties both registers, returns to hunting for
// a dollar sign and loads the register defaults.

module nmea_sentence_validator
  import nsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  body_length,
  output logic [8:0]  token_count,
  output logic [7:0]  computed_checksum,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  nsv_cfg_t    cfg;
  nsv_state_t  state;
  nsv_result_t result;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        hold;
  logic        step;
  logic        sentence_end;

  // The pipeline only freezes while a finished verdict waits to be taken.
  assign hold     = out_valid && out_stall;
  assign step     = s1_valid && !hold;
  assign in_stall = s1_valid && hold;

  nsv_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  nsv_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .rx_byte      (s1_byte),
    .cfg          (cfg),
    .sentence_end (sentence_end),
    .state        (state)
  );

  nsv_verdict u_verdict (
    .state  (state),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (!hold) begin
        out_valid <= sentence_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
    if (sentence_end) begin
      status            <= result.status;
      body_length       <= result.body_length;
      token_count       <= result.token_count;
      computed_checksum <= result.computed_checksum;
    end
  end

endmodule
